FILE: src/assert_macros.svh
// Assertion macros used by the parser RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define LLP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ll1p_pkg.sv
// Package for the LL(1) parser: symbol and result codes, row ROM, shared types.
// No dependencies; used by every other file of the block but ll1p_ram and assert_macros.svh.
package ll1p_pkg;

  localparam int RETURN_DEPTH_DEF   = 32;
  localparam int OPERATOR_DEPTH_DEF = 32;
  localparam int TABLE_ROWS_DEF     = 110;
  localparam int MAX_RESULTS        = 40;
  localparam int VISIT_LIMIT        = 1024;

  localparam int SYM_W  = 5;
  localparam int REF_W  = 12;
  localparam int POS_W  = 16;
  localparam int KIND_W = 3;
  localparam int OPC_W  = 3;
  localparam int ROW_W  = 7;
  localparam int SET_W  = 17;

  localparam logic [ROW_W-1:0] RESET_ROW  = 7'd1;
  localparam logic [ROW_W-1:0] RESUME_ROW = 7'd3;

  // token symbols
  localparam logic [SYM_W-1:0] SYM_INT   = 5'd0;
  localparam logic [SYM_W-1:0] SYM_FLOAT = 5'd1;
  localparam logic [SYM_W-1:0] SYM_ID    = 5'd2;
  localparam logic [SYM_W-1:0] SYM_CONST = 5'd3;
  localparam logic [SYM_W-1:0] SYM_EQ    = 5'd8;
  localparam logic [SYM_W-1:0] SYM_NE    = 5'd9;
  localparam logic [SYM_W-1:0] SYM_LT    = 5'd10;
  localparam logic [SYM_W-1:0] SYM_GT    = 5'd11;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 5'd12;
  localparam logic [SYM_W-1:0] SYM_MINUS = 5'd13;
  localparam logic [SYM_W-1:0] SYM_MUL   = 5'd14;
  localparam logic [SYM_W-1:0] SYM_SEMI  = 5'd5;
  localparam logic [SYM_W-1:0] SYM_EOF   = 5'd16;
  localparam logic [SYM_W-1:0] SYM_KNOWN = 5'd17;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_OPERAND  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ASSIGN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ELEMENT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FINISH   = 3'd5;

  // operator codes
  localparam logic [OPC_W-1:0] OPC_PLUS  = 3'd0;
  localparam logic [OPC_W-1:0] OPC_MINUS = 3'd1;
  localparam logic [OPC_W-1:0] OPC_MUL   = 3'd2;
  localparam logic [OPC_W-1:0] OPC_EQ    = 3'd3;
  localparam logic [OPC_W-1:0] OPC_NE    = 3'd4;
  localparam logic [OPC_W-1:0] OPC_LT    = 3'd5;
  localparam logic [OPC_W-1:0] OPC_GT    = 3'd6;

  // expected-set bits
  localparam logic [SET_W-1:0] B_TI = 17'h00001;
  localparam logic [SET_W-1:0] B_TF = 17'h00002;
  localparam logic [SET_W-1:0] B_ID = 17'h00004;
  localparam logic [SET_W-1:0] B_CN = 17'h00008;
  localparam logic [SET_W-1:0] B_AS = 17'h00010;
  localparam logic [SET_W-1:0] B_SE = 17'h00020;
  localparam logic [SET_W-1:0] B_LB = 17'h00040;
  localparam logic [SET_W-1:0] B_RB = 17'h00080;
  localparam logic [SET_W-1:0] B_EQ = 17'h00100;
  localparam logic [SET_W-1:0] B_NE = 17'h00200;
  localparam logic [SET_W-1:0] B_LT = 17'h00400;
  localparam logic [SET_W-1:0] B_GT = 17'h00800;
  localparam logic [SET_W-1:0] B_PL = 17'h01000;
  localparam logic [SET_W-1:0] B_MI = 17'h02000;
  localparam logic [SET_W-1:0] B_MU = 17'h04000;
  localparam logic [SET_W-1:0] B_CM = 17'h08000;
  localparam logic [SET_W-1:0] B_EF = 17'h10000;
  localparam logic [SET_W-1:0] M_REL  = B_EQ | B_NE | B_LT | B_GT;
  localparam logic [SET_W-1:0] M_ADDF = B_SE | B_RB | B_CM | M_REL;
  localparam logic [SET_W-1:0] M_MULF = B_PL | B_MI | M_ADDF;
  localparam logic [SET_W-1:0] M_OPND = B_ID | B_CN | B_LB;

  // row flags
  localparam logic [3:0] F_ACC = 4'b0001;
  localparam logic [3:0] F_PSH = 4'b0010;
  localparam logic [3:0] F_RET = 4'b0100;
  localparam logic [3:0] F_ERR = 4'b1000;

  typedef enum logic [1:0] {ACT_NONE, ACT_ASG, ACT_POP, ACT_AEM} act_t;

  typedef struct packed {
    logic [SET_W-1:0] set;
    logic [ROW_W-1:0] jump;
    logic             acc;
    logic             psh;
    logic             ret;
    logic             err;
    act_t             act;
  } row_t;

  typedef struct packed {
    logic [SET_W-1:0] symbit;
    logic [SYM_W-1:0] sym;
    logic [REF_W-1:0] lref;
    logic [POS_W-1:0] pos;
    logic [OPC_W-1:0] opc;
    logic             opv;
  } tok_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [REF_W-1:0]  oref;
    logic [OPC_W-1:0]  opc;
    logic [POS_W-1:0]  pos;
    logic              fe;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK, ST_OPWAIT, ST_RETWAIT, ST_FIN, ST_FLUSH
  } back_state_t;

  function automatic row_t mk(input logic [SET_W-1:0] s, input logic [ROW_W-1:0] j,
                              input logic [3:0] f, input act_t a);
    row_t e;
    e.set  = s;
    e.jump = j;
    e.acc  = f[0];
    e.psh  = f[1];
    e.ret  = f[2];
    e.err  = f[3];
    e.act  = a;
    return e;
  endfunction

  function automatic row_t row_lookup(input logic [ROW_W-1:0] r);
    row_t e;
    e = '0;
    case (r)
      7'd1:   e = mk(B_TI | B_TF | B_ID | B_EF, 7'd2, F_ERR, ACT_NONE);
      7'd2:   e = mk('0, 7'd3, F_RET | F_ERR, ACT_NONE);
      7'd3:   e = mk(B_TI | B_TF | B_ID, 7'd5, 4'b0, ACT_NONE);
      7'd4:   e = mk(B_EF, 7'd7, F_ERR, ACT_NONE);
      7'd5:   e = mk('0, 7'd8, F_PSH | F_ERR, ACT_NONE);
      7'd6:   e = mk('0, 7'd3, F_RET | F_ERR, ACT_NONE);
      7'd7:   e = mk(B_EF, 7'd0, F_RET | F_ERR, ACT_NONE);
      7'd8:   e = mk(B_TI | B_TF, 7'd10, 4'b0, ACT_NONE);
      7'd9:   e = mk(B_ID, 7'd14, F_ERR, ACT_NONE);
      7'd10:  e = mk('0, 7'd19, F_PSH | F_ERR, ACT_NONE);
      7'd11:  e = mk(B_ID, 7'd12, F_ACC | F_ERR, ACT_NONE);
      7'd12:  e = mk('0, 7'd23, F_PSH | F_ERR, ACT_NONE);
      7'd13:  e = mk(B_SE, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd14:  e = mk(B_ID, 7'd93, F_ACC | F_ERR, ACT_NONE);
      7'd15:  e = mk(B_AS, 7'd16, F_ACC | F_ERR, ACT_NONE);
      7'd16:  e = mk('0, 7'd33, F_PSH | F_ERR, ACT_NONE);
      7'd17:  e = mk('0, 7'd18, F_ERR, ACT_ASG);
      7'd18:  e = mk(B_SE, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd19:  e = mk(B_TI, 7'd21, 4'b0, ACT_NONE);
      7'd20:  e = mk(B_TF, 7'd22, F_ERR, ACT_NONE);
      7'd21:  e = mk(B_TI, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd22:  e = mk(B_TF, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd23:  e = mk(B_AS, 7'd26, 4'b0, ACT_NONE);
      7'd24:  e = mk(B_LB, 7'd29, 4'b0, ACT_NONE);
      7'd25:  e = mk(B_SE, 7'd32, F_ERR, ACT_NONE);
      7'd26:  e = mk(B_AS, 7'd27, F_ACC | F_ERR, ACT_NONE);
      7'd27:  e = mk('0, 7'd33, F_PSH | F_ERR, ACT_NONE);
      7'd28:  e = mk('0, 7'd0, F_RET | F_ERR, ACT_ASG);
      7'd29:  e = mk(B_LB, 7'd30, F_ACC | F_ERR, ACT_NONE);
      7'd30:  e = mk(B_CN, 7'd31, F_ACC | F_ERR, ACT_NONE);
      7'd31:  e = mk(B_RB, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd32:  e = mk(B_SE, 7'd0, F_RET | F_ERR, ACT_NONE);
      7'd33:  e = mk(M_OPND, 7'd34, F_ERR, ACT_NONE);
      7'd34:  e = mk('0, 7'd50, F_PSH | F_ERR, ACT_NONE);
      7'd35:  e = mk('0, 7'd36, F_RET | F_ERR, ACT_NONE);
      7'd36:  e = mk(M_REL, 7'd38, 4'b0, ACT_NONE);
      7'd37:  e = mk(B_SE | B_RB | B_CM, 7'd41, F_ERR, ACT_NONE);
      7'd38:  e = mk('0, 7'd42, F_PSH | F_ERR, ACT_NONE);
      7'd39:  e = mk('0, 7'd50, F_PSH | F_ERR, ACT_NONE);
      7'd40:  e = mk('0, 7'd0, F_RET | F_ERR, ACT_POP);
      7'd41:  e = mk(B_SE | B_RB | B_CM, 7'd0, F_RET | F_ERR, ACT_NONE);
      7'd42:  e = mk(B_EQ, 7'd46, 4'b0, ACT_NONE);
      7'd43:  e = mk(B_NE, 7'd47, 4'b0, ACT_NONE);
      7'd44:  e = mk(B_LT, 7'd48, 4'b0, ACT_NONE);
      7'd45:  e = mk(B_GT, 7'd49, F_ERR, ACT_NONE);
      7'd46:  e = mk(B_EQ, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd47:  e = mk(B_NE, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd48:  e = mk(B_LT, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd49:  e = mk(B_GT, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd50:  e = mk(M_OPND, 7'd51, F_ERR, ACT_NONE);
      7'd51:  e = mk('0, 7'd64, F_PSH | F_ERR, ACT_NONE);
      7'd52:  e = mk('0, 7'd53, F_RET | F_ERR, ACT_NONE);
      7'd53:  e = mk(B_PL | B_MI, 7'd55, 4'b0, ACT_NONE);
      7'd54:  e = mk(M_ADDF, 7'd59, F_ERR, ACT_NONE);
      7'd55:  e = mk('0, 7'd60, F_PSH | F_ERR, ACT_NONE);
      7'd56:  e = mk('0, 7'd64, F_PSH | F_ERR, ACT_NONE);
      7'd57:  e = mk('0, 7'd58, F_ERR, ACT_POP);
      7'd58:  e = mk('0, 7'd53, F_RET | F_ERR, ACT_NONE);
      7'd59:  e = mk(M_ADDF, 7'd0, F_RET | F_ERR, ACT_NONE);
      7'd60:  e = mk(B_PL, 7'd62, 4'b0, ACT_NONE);
      7'd61:  e = mk(B_MI, 7'd63, F_ERR, ACT_NONE);
      7'd62:  e = mk(B_PL, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd63:  e = mk(B_MI, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd64:  e = mk(M_OPND, 7'd65, F_ERR, ACT_NONE);
      7'd65:  e = mk('0, 7'd74, F_PSH | F_ERR, ACT_NONE);
      7'd66:  e = mk('0, 7'd67, F_RET | F_ERR, ACT_NONE);
      7'd67:  e = mk(B_MU, 7'd69, 4'b0, ACT_NONE);
      7'd68:  e = mk(M_MULF, 7'd73, F_ERR, ACT_NONE);
      7'd69:  e = mk(B_MU, 7'd70, F_ACC | F_ERR, ACT_NONE);
      7'd70:  e = mk('0, 7'd74, F_PSH | F_ERR, ACT_NONE);
      7'd71:  e = mk('0, 7'd72, F_ERR, ACT_POP);
      7'd72:  e = mk('0, 7'd67, F_RET | F_ERR, ACT_NONE);
      7'd73:  e = mk(M_MULF, 7'd0, F_RET | F_ERR, ACT_NONE);
      7'd74:  e = mk(B_ID, 7'd77, 4'b0, ACT_NONE);
      7'd75:  e = mk(B_CN, 7'd78, 4'b0, ACT_NONE);
      7'd76:  e = mk(B_LB, 7'd79, F_ERR, ACT_NONE);
      7'd77:  e = mk(B_ID, 7'd100, F_ACC | F_ERR, ACT_NONE);
      7'd78:  e = mk(B_CN, 7'd0, F_ACC | F_RET | F_ERR, ACT_NONE);
      7'd79:  e = mk(B_LB, 7'd80, F_ACC | F_ERR, ACT_NONE);
      7'd80:  e = mk('0, 7'd82, F_PSH | F_ERR, ACT_NONE);
      7'd81:  e = mk(B_RB, 7'd0, F_ACC | F_RET | F_ERR, ACT_AEM);
      7'd82:  e = mk(M_OPND, 7'd84, 4'b0, ACT_NONE);
      7'd83:  e = mk(B_RB, 7'd86, F_ERR, ACT_NONE);
      7'd84:  e = mk('0, 7'd33, F_PSH | F_ERR, ACT_NONE);
      7'd85:  e = mk('0, 7'd87, F_RET | F_ERR, ACT_NONE);
      7'd86:  e = mk(B_RB, 7'd0, F_RET | F_ERR, ACT_NONE);
      7'd87:  e = mk(B_CM, 7'd89, 4'b0, ACT_NONE);
      7'd88:  e = mk(B_RB, 7'd92, F_ERR, ACT_NONE);
      7'd89:  e = mk(B_CM, 7'd90, F_ACC | F_ERR, ACT_NONE);
      7'd90:  e = mk('0, 7'd33, F_PSH | F_ERR, ACT_NONE);
      7'd91:  e = mk('0, 7'd87, F_RET | F_ERR, ACT_NONE);
      7'd92:  e = mk(B_RB, 7'd0, F_RET | F_ERR, ACT_NONE);
      7'd93:  e = mk(B_AS, 7'd16, F_ACC, ACT_NONE);
      7'd94:  e = mk(B_LB, 7'd95, F_ACC | F_ERR, ACT_NONE);
      7'd95:  e = mk('0, 7'd33, F_PSH | F_ERR, ACT_NONE);
      7'd96:  e = mk(B_RB, 7'd97, F_ACC | F_ERR, ACT_AEM);
      7'd97:  e = mk(B_AS, 7'd98, F_ACC | F_ERR, ACT_NONE);
      7'd98:  e = mk('0, 7'd33, F_PSH | F_ERR, ACT_NONE);
      7'd99:  e = mk('0, 7'd18, F_ERR, ACT_ASG);
      7'd100: e = mk(B_LB, 7'd102, 4'b0, ACT_NONE);
      7'd101: e = mk('0, 7'd0, F_RET | F_ERR, ACT_NONE);
      7'd102: e = mk(B_LB, 7'd103, F_ACC | F_ERR, ACT_NONE);
      7'd103: e = mk('0, 7'd33, F_PSH | F_ERR, ACT_NONE);
      7'd104: e = mk(B_RB, 7'd0, F_ACC | F_RET | F_ERR, ACT_AEM);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

FILE: src/ll1p_tok_if.sv
// Token channel: valid/ready handshake with symbol code and lexeme reference.
// Depends on ll1p_pkg for field widths.
interface ll1p_tok_if import ll1p_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] token_sym;
  logic [REF_W-1:0] lexeme_ref;

  modport source (output valid, token_sym, lexeme_ref, input ready);
  modport sink   (input valid, token_sym, lexeme_ref, output ready);
endinterface

FILE: src/ll1p_rpn_if.sv
// Result channel: valid/ready handshake carrying one reverse-Polish word.
// Depends on ll1p_pkg for field widths.
interface ll1p_rpn_if import ll1p_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  logic [REF_W-1:0]  operand_ref;
  logic [OPC_W-1:0]  operator_code;
  logic [POS_W-1:0]  error_position;
  logic              finished_with_errors;
  logic              last_of_run;

  modport source (output valid, out_kind, operand_ref, operator_code, error_position,
                  finished_with_errors, last_of_run, input ready);
  modport sink   (input valid, out_kind, operand_ref, operator_code, error_position,
                  finished_with_errors, last_of_run, output ready);
endinterface

FILE: src/ll1p_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ll1p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/ll1p_front.sv
// Front end: accepts tokens, numbers them and precomputes symbol classes.
// Depends on ll1p_pkg and ll1p_tok_if.
module ll1p_front import ll1p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ll1p_tok_if.sink   token,
  output logic       item_valid,
  input  logic       item_ready,
  output tok_item_t  item
);
  logic [POS_W-1:0] token_count;

  assign token.ready = item_ready;
  assign item_valid  = token.valid;

  always_comb begin
    item.sym    = token.token_sym;
    item.lref   = token.lexeme_ref;
    item.pos    = token_count;
    item.symbit = (token.token_sym < SYM_KNOWN) ? (SET_W'(1) << token.token_sym) : '0;
    item.opv    = 1'b1;
    case (token.token_sym)
      SYM_PLUS:  item.opc = OPC_PLUS;
      SYM_MINUS: item.opc = OPC_MINUS;
      SYM_MUL:   item.opc = OPC_MUL;
      SYM_EQ:    item.opc = OPC_EQ;
      SYM_NE:    item.opc = OPC_NE;
      SYM_LT:    item.opc = OPC_LT;
      SYM_GT:    item.opc = OPC_GT;
      default: begin
        item.opc = OPC_PLUS;
        item.opv = 1'b0;
      end
    endcase
  end

  // saturating token index
  always_ff @(posedge clk) begin
    if (rst) begin
      token_count <= '0;
    end else if (token.valid && token.ready && token_count != '1) begin
      token_count <= token_count + POS_W'(1);
    end
  end
endmodule

FILE: src/ll1p_queue.sv
// Two-entry queue between the token front end and the parse engine.
// Depends on ll1p_pkg.
module ll1p_queue import ll1p_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tok_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output tok_item_t out_item
);
  tok_item_t  ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_item  = ent[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: src/ll1p_back.sv
// Parse engine: walks the row ROM over the stacks and emits result words.
// Depends on ll1p_pkg, ll1p_rpn_if, ll1p_ram and assert_macros.svh.
`include "assert_macros.svh"
module ll1p_back import ll1p_pkg::*; #(
  parameter int RETURN_DEPTH   = RETURN_DEPTH_DEF,
  parameter int OPERATOR_DEPTH = OPERATOR_DEPTH_DEF,
  parameter int TABLE_ROWS     = TABLE_ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  tok_item_t q_item,
  ll1p_rpn_if.source result
);
  localparam int RAW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
  localparam int OAW = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;
  localparam int RCW = $clog2(RETURN_DEPTH + 1);
  localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
  localparam int VW  = $clog2(VISIT_LIMIT + 1);
  localparam int NW  = $clog2(MAX_RESULTS + 1);

  back_state_t state, state_next;

  logic [ROW_W-1:0] parse_row, parse_row_next;
  logic [RCW-1:0]   rc, rc_next, rc_m1;
  logic [OCW-1:0]   oc, oc_next, oc_m1;
  logic             error_seen, error_seen_next;
  logic             skipping, skipping_next;
  logic             halted, halted_next;
  logic [VW-1:0]    visits, visits_next;
  logic [NW-1:0]    res_n, res_n_next;
  tok_item_t        cur, cur_next;
  logic             consumed, consumed_next;
  logic             pend_v, pend_v_next;
  res_t             pend, pend_next;
  logic             out_v, out_v_next;
  res_t             out_r, out_r_next;
  logic             out_last, out_last_next;

  logic             ret_we, op_we;
  logic [ROW_W-1:0] ret_rdata;
  logic [OPC_W-1:0] op_rdata;

  row_t e;
  logic out_free, row_end, match, visit_max, is_opnd;
  logic op_push, op_ovf, pop_op, tail_ovf, tail_fin, tail_ret, cons_eff;
  logic is_semi, is_type, is_eof, q_semi, q_type, q_eof;
  logic emit_req, emit_ok;
  res_t emit_item;
  back_state_t tail_state;

  assign e         = row_lookup(parse_row);
  assign out_free  = !out_v || result.ready;
  assign row_end   = (parse_row == '0) || ({1'b0, parse_row} >= (ROW_W + 1)'(TABLE_ROWS));
  assign match     = (e.set == '0) || ((e.set & cur.symbit) != '0);
  assign visit_max = (visits == VW'(VISIT_LIMIT));
  assign is_semi   = (cur.sym == SYM_SEMI);
  assign is_type   = (cur.sym == SYM_INT) || (cur.sym == SYM_FLOAT);
  assign is_eof    = (cur.sym == SYM_EOF);
  assign is_opnd   = (cur.sym == SYM_ID) || (cur.sym == SYM_CONST);
  assign q_semi    = (q_item.sym == SYM_SEMI);
  assign q_type    = (q_item.sym == SYM_INT) || (q_item.sym == SYM_FLOAT);
  assign q_eof     = (q_item.sym == SYM_EOF);
  assign rc_m1     = rc - RCW'(1);
  assign oc_m1     = oc - OCW'(1);

  assign op_push  = e.acc && cur.opv;
  assign op_ovf   = op_push && (oc == OCW'(OPERATOR_DEPTH));
  assign pop_op   = (e.act == ACT_POP) && (oc != '0);
  assign tail_ovf = e.psh && (rc == RCW'(RETURN_DEPTH));
  assign tail_fin = !tail_ovf && (e.jump == '0) && e.ret && (rc == '0);
  assign tail_ret = !tail_ovf && (e.jump == '0) && e.ret && (rc != '0);
  assign cons_eff = (state == ST_WALK) ? e.acc : consumed;

  always_comb begin
    if (tail_ovf || tail_fin) begin
      tail_state = ST_FIN;
    end else if (tail_ret) begin
      tail_state = ST_RETWAIT;
    end else if (cons_eff) begin
      tail_state = ST_FLUSH;
    end else begin
      tail_state = ST_WALK;
    end
  end

  ll1p_ram #(.WIDTH(ROW_W), .DEPTH(RETURN_DEPTH)) u_ret_ram (
    .clk   (clk),
    .we    (ret_we),
    .waddr (rc[RAW-1:0]),
    .wdata (parse_row + ROW_W'(1)),
    .raddr (rc_m1[RAW-1:0]),
    .rdata (ret_rdata)
  );

  ll1p_ram #(.WIDTH(OPC_W), .DEPTH(OPERATOR_DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (oc[OAW-1:0]),
    .wdata (cur.opc),
    .raddr (oc_m1[OAW-1:0]),
    .rdata (op_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && !halted) begin
          if (!skipping) state_next = ST_WALK;
          else if (q_type) state_next = ST_WALK;
          else if (q_eof) state_next = ST_FIN;
        end
      end
      ST_WALK: begin
        if (out_free) begin
          if (visit_max) state_next = ST_FLUSH;
          else if (row_end) state_next = ST_FIN;
          else if (!match) begin
            if (!e.err || is_type) state_next = ST_WALK;
            else if (is_eof) state_next = ST_FIN;
            else state_next = ST_FLUSH;
          end else if (op_ovf) state_next = ST_FIN;
          else if (pop_op) state_next = ST_OPWAIT;
          else state_next = tail_state;
        end
      end
      ST_OPWAIT: begin
        if (out_free) state_next = tail_state;
      end
      ST_RETWAIT: begin
        state_next = consumed ? ST_FLUSH : ST_WALK;
      end
      ST_FIN: begin
        if (out_free) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    parse_row_next  = parse_row;
    rc_next         = rc;
    oc_next         = oc;
    error_seen_next = error_seen;
    skipping_next   = skipping;
    halted_next     = halted;
    visits_next     = visits;
    res_n_next      = res_n;
    cur_next        = cur;
    consumed_next   = consumed;
    q_ready         = 1'b0;
    ret_we          = 1'b0;
    op_we           = 1'b0;
    emit_req        = 1'b0;
    emit_item       = '0;

    case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cur_next    = q_item;
          visits_next = '0;
          res_n_next  = '0;
          if (!halted && skipping && (q_semi || q_type)) begin
            skipping_next  = 1'b0;
            rc_next        = '0;
            parse_row_next = RESUME_ROW;
          end
        end
      end
      ST_WALK: begin
        if (out_free && !visit_max && !row_end) begin
          visits_next = visits + VW'(1);
          if (!match) begin
            if (!e.err) begin
              parse_row_next = parse_row + ROW_W'(1);
            end else begin
              error_seen_next = 1'b1;
              emit_req        = 1'b1;
              emit_item.kind  = KIND_ERROR;
              emit_item.pos   = cur.pos;
              if (is_semi || is_type) begin
                rc_next        = '0;
                parse_row_next = RESUME_ROW;
              end else if (!is_eof) begin
                skipping_next = 1'b1;
              end
            end
          end else begin
            consumed_next = e.acc;
            if (op_ovf) begin
              error_seen_next = 1'b1;
              emit_req        = 1'b1;
              emit_item.kind  = KIND_ERROR;
              emit_item.pos   = cur.pos;
            end else begin
              if (e.acc && is_opnd) begin
                emit_req       = 1'b1;
                emit_item.kind = KIND_OPERAND;
                emit_item.oref = cur.lref;
              end
              if (op_push) begin
                op_we   = 1'b1;
                oc_next = oc + OCW'(1);
              end
              if (e.act == ACT_ASG) begin
                emit_req       = 1'b1;
                emit_item.kind = KIND_ASSIGN;
              end
              if (e.act == ACT_AEM) begin
                emit_req       = 1'b1;
                emit_item.kind = KIND_ELEMENT;
              end
              if (pop_op) begin
                oc_next = oc_m1;
              end else if (tail_ovf) begin
                error_seen_next = 1'b1;
                emit_req        = 1'b1;
                emit_item.kind  = KIND_ERROR;
                emit_item.pos   = cur.pos;
              end else begin
                if (e.psh) begin
                  ret_we  = 1'b1;
                  rc_next = rc + RCW'(1);
                end
                if (e.jump != '0) parse_row_next = e.jump;
                else if (tail_ret) rc_next = rc_m1;
                else if (!e.ret) parse_row_next = parse_row + ROW_W'(1);
              end
            end
          end
        end
      end
      ST_OPWAIT: begin
        if (out_free) begin
          emit_req       = 1'b1;
          emit_item.kind = KIND_OPERATOR;
          emit_item.opc  = op_rdata;
          if (e.jump != '0) parse_row_next = e.jump;
          else if (tail_ret) rc_next = rc_m1;
          else if (!e.ret) parse_row_next = parse_row + ROW_W'(1);
        end
      end
      ST_RETWAIT: begin
        parse_row_next = ret_rdata;
      end
      ST_FIN: begin
        if (out_free) begin
          emit_req       = 1'b1;
          emit_item.kind = KIND_FINISH;
          emit_item.fe   = error_seen;
          halted_next    = 1'b1;
        end
      end
      ST_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

  // hold one word back so the last word of a token can be marked
  assign emit_ok = emit_req && (res_n < NW'(MAX_RESULTS));

  always_comb begin
    pend_v_next   = pend_v;
    pend_next     = pend;
    out_v_next    = out_v && !result.ready;
    out_r_next    = out_r;
    out_last_next = out_last;
    if (emit_ok) begin
      if (pend_v) begin
        out_v_next    = 1'b1;
        out_r_next    = pend;
        out_last_next = 1'b0;
      end
      pend_next   = emit_item;
      pend_v_next = 1'b1;
    end
    if (state == ST_FLUSH && out_free && pend_v) begin
      out_v_next    = 1'b1;
      out_r_next    = pend;
      out_last_next = 1'b1;
      pend_v_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      parse_row  <= RESET_ROW;
      rc         <= '0;
      oc         <= '0;
      error_seen <= 1'b0;
      skipping   <= 1'b0;
      halted     <= 1'b0;
      visits     <= '0;
      res_n      <= '0;
      consumed   <= 1'b0;
      pend_v     <= 1'b0;
      out_v      <= 1'b0;
    end else begin
      state      <= state_next;
      parse_row  <= parse_row_next;
      rc         <= rc_next;
      oc         <= oc_next;
      error_seen <= error_seen_next;
      skipping   <= skipping_next;
      halted     <= halted_next;
      visits     <= visits_next;
      res_n      <= emit_ok ? res_n_next + NW'(1) : res_n_next;
      consumed   <= consumed_next;
      pend_v     <= pend_v_next;
      out_v      <= out_v_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    pend     <= pend_next;
    out_r    <= out_r_next;
    out_last <= out_last_next;
  end

  assign result.valid                = out_v;
  assign result.out_kind             = out_r.kind;
  assign result.operand_ref          = out_r.oref;
  assign result.operator_code        = out_r.opc;
  assign result.error_position       = out_r.pos;
  assign result.finished_with_errors = out_r.fe;
  assign result.last_of_run          = out_last;

  `LLP_ASSERT(a_rc_bound, clk, rst, rc <= RCW'(RETURN_DEPTH), "return count past depth")
  `LLP_ASSERT(a_halt_sticky, clk, rst, halted |=> halted, "halted flag dropped")
  `LLP_ASSERT(a_idle_drained, clk, rst, (state == ST_IDLE) |-> !pend_v, "word held in idle")
endmodule

FILE: src/ll1_table_parser_to_rpn.sv
// Top level of the LL(1) table-driven parser that emits reverse-Polish words.
// Depends on ll1p_pkg, both channel interfaces, ll1p_front, ll1p_queue and ll1p_back.
//
// Tokens (symbol code plus lexeme reference) enter on the token channel and
// reverse-Polish words leave on the result channel: operands, operators
// popped from the operator stack, assign and array-element markers, syntax
// errors with the token position, and one finish word, after which the block
// halts and drops every further token until reset. The last word that a token
// causes carries last_of_run; at most 40 words leave per token. A front end
// numbers and classifies tokens into a two-entry queue, so the next token is
// taken while the parse engine works. The engine steps one ROM row per cycle
// while the result channel can take a word; a row that returns through the
// return stack or pops an operator waits in ST_RETWAIT or ST_OPWAIT for the
// registered stack RAM read, and at the end of a token's walk ST_FLUSH releases
// the held-back last word before ST_IDLE fetches the next token. A token's time
// is set by the rows its walk visits, its returns and pops, and any stall on the
// result channel: an operand right after '=' visits nine rows, and the ';' that
// closes such a statement visits 16 rows with five returns.
// Stack overflow reports an error, then finishes and halts. Both
// stacks live in RAMs with no clearing pass; the block is ready right after
// reset.
module ll1_table_parser_to_rpn import ll1p_pkg::*; #(
  parameter int RETURN_DEPTH   = RETURN_DEPTH_DEF,
  parameter int OPERATOR_DEPTH = OPERATOR_DEPTH_DEF,
  parameter int TABLE_ROWS     = TABLE_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ll1p_tok_if.sink   token,
  ll1p_rpn_if.source result
);
  logic      f_valid, f_ready;
  tok_item_t f_item;
  logic      q_valid, q_ready;
  tok_item_t q_item;

  // number tokens and classify their symbols
  ll1p_front u_front (
    .clk        (clk),
    .rst        (rst),
    .token      (token),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // decouple intake from the parse walk
  ll1p_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // walk the ROM and emit words
  ll1p_back #(
    .RETURN_DEPTH   (RETURN_DEPTH),
    .OPERATOR_DEPTH (OPERATOR_DEPTH),
    .TABLE_ROWS     (TABLE_ROWS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .result  (result)
  );
endmodule

FILE: bench/tb_ll1_table_parser_to_rpn.sv
// Testbench for ll1_table_parser_to_rpn: drives classified tokens and scores every RPN word.
// Depends on ll1p_pkg and the token and result channel interfaces from the RTL.
module tb_ll1_table_parser_to_rpn;
  import ll1p_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // token codes the package leaves unnamed
  localparam logic [SYM_W-1:0] T_BECOMES = 5'd4;
  localparam logic [SYM_W-1:0] T_LBR     = 5'd6;
  localparam logic [SYM_W-1:0] T_RBR     = 5'd7;
  localparam logic [SYM_W-1:0] T_COMMA   = 5'd15;
  localparam logic [SYM_W-1:0] T_JUNK    = 5'd31;

  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_WAIT  = 100;

  typedef struct {
    logic [SYM_W-1:0] sym;
    logic [REF_W-1:0] lref;
  } token_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [REF_W-1:0]  oref;
    logic [OPC_W-1:0]  opc;
    logic [POS_W-1:0]  pos;
    logic              fe;
    logic              last;
  } rpn_word_t;

  logic clk;
  logic rst;

  ll1p_tok_if tok ();
  ll1p_rpn_if rpn ();

  ll1_table_parser_to_rpn dut (
    .clk    (clk),
    .rst    (rst),
    .token  (tok),
    .result (rpn)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // Parse table: expected set, jump row, flags and action for each row.
  // ---------------------------------------------------------------------
  logic [SET_W-1:0] tbl_set  [128];
  logic [ROW_W-1:0] tbl_jump [128];
  logic [3:0]       tbl_flag [128];
  act_t             tbl_act  [128];

  function automatic void put_row(int r, logic [SET_W-1:0] s, int j, logic [3:0] f, act_t a);
    tbl_set[r]  = s;
    tbl_jump[r] = ROW_W'(j);
    tbl_flag[r] = f;
    tbl_act[r]  = a;
  endfunction

  function automatic void load_table();
    for (int i = 0; i < 128; i++) put_row(i, '0, 0, 4'b0, ACT_NONE);
    put_row(1, B_TI | B_TF | B_ID | B_EF, 2, F_ERR, ACT_NONE);
    put_row(2, '0, 3, F_RET | F_ERR, ACT_NONE);
    put_row(3, B_TI | B_TF | B_ID, 5, 4'b0, ACT_NONE);
    put_row(4, B_EF, 7, F_ERR, ACT_NONE);
    put_row(5, '0, 8, F_PSH | F_ERR, ACT_NONE);
    put_row(6, '0, 3, F_RET | F_ERR, ACT_NONE);
    put_row(7, B_EF, 0, F_RET | F_ERR, ACT_NONE);
    put_row(8, B_TI | B_TF, 10, 4'b0, ACT_NONE);
    put_row(9, B_ID, 14, F_ERR, ACT_NONE);
    put_row(10, '0, 19, F_PSH | F_ERR, ACT_NONE);
    put_row(11, B_ID, 12, F_ACC | F_ERR, ACT_NONE);
    put_row(12, '0, 23, F_PSH | F_ERR, ACT_NONE);
    put_row(13, B_SE, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(14, B_ID, 93, F_ACC | F_ERR, ACT_NONE);
    put_row(15, B_AS, 16, F_ACC | F_ERR, ACT_NONE);
    put_row(16, '0, 33, F_PSH | F_ERR, ACT_NONE);
    put_row(17, '0, 18, F_ERR, ACT_ASG);
    put_row(18, B_SE, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(19, B_TI, 21, 4'b0, ACT_NONE);
    put_row(20, B_TF, 22, F_ERR, ACT_NONE);
    put_row(21, B_TI, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(22, B_TF, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(23, B_AS, 26, 4'b0, ACT_NONE);
    put_row(24, B_LB, 29, 4'b0, ACT_NONE);
    put_row(25, B_SE, 32, F_ERR, ACT_NONE);
    put_row(26, B_AS, 27, F_ACC | F_ERR, ACT_NONE);
    put_row(27, '0, 33, F_PSH | F_ERR, ACT_NONE);
    put_row(28, '0, 0, F_RET | F_ERR, ACT_ASG);
    put_row(29, B_LB, 30, F_ACC | F_ERR, ACT_NONE);
    put_row(30, B_CN, 31, F_ACC | F_ERR, ACT_NONE);
    put_row(31, B_RB, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(32, B_SE, 0, F_RET | F_ERR, ACT_NONE);
    put_row(33, M_OPND, 34, F_ERR, ACT_NONE);
    put_row(34, '0, 50, F_PSH | F_ERR, ACT_NONE);
    put_row(35, '0, 36, F_RET | F_ERR, ACT_NONE);
    put_row(36, M_REL, 38, 4'b0, ACT_NONE);
    put_row(37, B_SE | B_RB | B_CM, 41, F_ERR, ACT_NONE);
    put_row(38, '0, 42, F_PSH | F_ERR, ACT_NONE);
    put_row(39, '0, 50, F_PSH | F_ERR, ACT_NONE);
    put_row(40, '0, 0, F_RET | F_ERR, ACT_POP);
    put_row(41, B_SE | B_RB | B_CM, 0, F_RET | F_ERR, ACT_NONE);
    put_row(42, B_EQ, 46, 4'b0, ACT_NONE);
    put_row(43, B_NE, 47, 4'b0, ACT_NONE);
    put_row(44, B_LT, 48, 4'b0, ACT_NONE);
    put_row(45, B_GT, 49, F_ERR, ACT_NONE);
    put_row(46, B_EQ, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(47, B_NE, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(48, B_LT, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(49, B_GT, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(50, M_OPND, 51, F_ERR, ACT_NONE);
    put_row(51, '0, 64, F_PSH | F_ERR, ACT_NONE);
    put_row(52, '0, 53, F_RET | F_ERR, ACT_NONE);
    put_row(53, B_PL | B_MI, 55, 4'b0, ACT_NONE);
    put_row(54, M_ADDF, 59, F_ERR, ACT_NONE);
    put_row(55, '0, 60, F_PSH | F_ERR, ACT_NONE);
    put_row(56, '0, 64, F_PSH | F_ERR, ACT_NONE);
    put_row(57, '0, 58, F_ERR, ACT_POP);
    put_row(58, '0, 53, F_RET | F_ERR, ACT_NONE);
    put_row(59, M_ADDF, 0, F_RET | F_ERR, ACT_NONE);
    put_row(60, B_PL, 62, 4'b0, ACT_NONE);
    put_row(61, B_MI, 63, F_ERR, ACT_NONE);
    put_row(62, B_PL, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(63, B_MI, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(64, M_OPND, 65, F_ERR, ACT_NONE);
    put_row(65, '0, 74, F_PSH | F_ERR, ACT_NONE);
    put_row(66, '0, 67, F_RET | F_ERR, ACT_NONE);
    put_row(67, B_MU, 69, 4'b0, ACT_NONE);
    put_row(68, M_MULF, 73, F_ERR, ACT_NONE);
    put_row(69, B_MU, 70, F_ACC | F_ERR, ACT_NONE);
    put_row(70, '0, 74, F_PSH | F_ERR, ACT_NONE);
    put_row(71, '0, 72, F_ERR, ACT_POP);
    put_row(72, '0, 67, F_RET | F_ERR, ACT_NONE);
    put_row(73, M_MULF, 0, F_RET | F_ERR, ACT_NONE);
    put_row(74, B_ID, 77, 4'b0, ACT_NONE);
    put_row(75, B_CN, 78, 4'b0, ACT_NONE);
    put_row(76, B_LB, 79, F_ERR, ACT_NONE);
    put_row(77, B_ID, 100, F_ACC | F_ERR, ACT_NONE);
    put_row(78, B_CN, 0, F_ACC | F_RET | F_ERR, ACT_NONE);
    put_row(79, B_LB, 80, F_ACC | F_ERR, ACT_NONE);
    put_row(80, '0, 82, F_PSH | F_ERR, ACT_NONE);
    put_row(81, B_RB, 0, F_ACC | F_RET | F_ERR, ACT_AEM);
    put_row(82, M_OPND, 84, 4'b0, ACT_NONE);
    put_row(83, B_RB, 86, F_ERR, ACT_NONE);
    put_row(84, '0, 33, F_PSH | F_ERR, ACT_NONE);
    put_row(85, '0, 87, F_RET | F_ERR, ACT_NONE);
    put_row(86, B_RB, 0, F_RET | F_ERR, ACT_NONE);
    put_row(87, B_CM, 89, 4'b0, ACT_NONE);
    put_row(88, B_RB, 92, F_ERR, ACT_NONE);
    put_row(89, B_CM, 90, F_ACC | F_ERR, ACT_NONE);
    put_row(90, '0, 33, F_PSH | F_ERR, ACT_NONE);
    put_row(91, '0, 87, F_RET | F_ERR, ACT_NONE);
    put_row(92, B_RB, 0, F_RET | F_ERR, ACT_NONE);
    put_row(93, B_AS, 16, F_ACC, ACT_NONE);
    put_row(94, B_LB, 95, F_ACC | F_ERR, ACT_NONE);
    put_row(95, '0, 33, F_PSH | F_ERR, ACT_NONE);
    put_row(96, B_RB, 97, F_ACC | F_ERR, ACT_AEM);
    put_row(97, B_AS, 98, F_ACC | F_ERR, ACT_NONE);
    put_row(98, '0, 33, F_PSH | F_ERR, ACT_NONE);
    put_row(99, '0, 18, F_ERR, ACT_ASG);
    put_row(100, B_LB, 102, 4'b0, ACT_NONE);
    put_row(101, '0, 0, F_RET | F_ERR, ACT_NONE);
    put_row(102, B_LB, 103, F_ACC | F_ERR, ACT_NONE);
    put_row(103, '0, 33, F_PSH | F_ERR, ACT_NONE);
    put_row(104, B_RB, 0, F_ACC | F_RET | F_ERR, ACT_AEM);
  endfunction

  // ---------------------------------------------------------------------
  // Parser shadow state and the words still owed by the block.
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] ret_stk [RETURN_DEPTH_DEF];
  int               ret_cnt;
  logic [OPC_W-1:0] op_stk [OPERATOR_DEPTH_DEF];
  int               op_cnt;
  logic             had_error;
  logic             in_panic;
  logic             is_halted;
  logic [POS_W-1:0] tok_index;
  logic [POS_W-1:0] cur_pos;

  rpn_word_t words_now [$];   // words caused by the token being parsed
  rpn_word_t rpn_owed [$];    // words the block still has to send

  int   fail_cnt;
  int   sent_cnt;
  int   cycle_cnt;
  int   src_idle_pct;
  int   snk_idle_pct;
  logic sink_hold = 1'b0;

  function automatic void emit_word(logic [KIND_W-1:0] k, logic [REF_W-1:0] r,
                                    logic [OPC_W-1:0] o, logic [POS_W-1:0] p, logic f);
    rpn_word_t w;
    if (words_now.size() >= MAX_RESULTS) return;
    w.kind = k;
    w.oref = r;
    w.opc  = o;
    w.pos  = p;
    w.fe   = f;
    w.last = 1'b0;
    words_now.insert(words_now.size(), w);
  endfunction

  function automatic void finish_parse();
    emit_word(KIND_FINISH, '0, '0, '0, had_error);
    is_halted = 1'b1;
  endfunction

  function automatic void stack_overflow();
    had_error = 1'b1;
    emit_word(KIND_ERROR, '0, '0, cur_pos, 1'b0);
    finish_parse();
  endfunction

  function automatic int opcode_of(logic [SYM_W-1:0] s);
    case (s)
      SYM_PLUS:  return OPC_PLUS;
      SYM_MINUS: return OPC_MINUS;
      SYM_MUL:   return OPC_MUL;
      SYM_EQ:    return OPC_EQ;
      SYM_NE:    return OPC_NE;
      SYM_LT:    return OPC_LT;
      SYM_GT:    return OPC_GT;
      default:   return -1;
    endcase
  endfunction

  function automatic void back_to_statements();
    ret_cnt = 0;
    cur_row = RESUME_ROW;
  endfunction

  // Walk table rows until the token is consumed, dropped or the parse ends.
  function automatic void walk_rows(logic [SYM_W-1:0] s, logic [REF_W-1:0] lr);
    int   r;
    int   oc;
    logic hit;
    logic took;
    for (int visits = 0; visits < VISIT_LIMIT && !is_halted; visits++) begin
      r = cur_row;
      if (r == 0 || r >= TABLE_ROWS_DEF) begin
        finish_parse();
        return;
      end
      hit = (tbl_set[r] == '0) || (s < SET_W && tbl_set[r][s]);
      if (!hit) begin
        if (!(tbl_flag[r] & F_ERR)) begin
          cur_row = ROW_W'(r + 1);
          continue;
        end
        had_error = 1'b1;
        emit_word(KIND_ERROR, '0, '0, cur_pos, 1'b0);
        if (s == SYM_SEMI) begin
          back_to_statements();
          return;
        end
        if (s == SYM_INT || s == SYM_FLOAT) begin
          back_to_statements();
          continue;
        end
        if (s == SYM_EOF) begin
          finish_parse();
          return;
        end
        in_panic = 1'b1;
        return;
      end
      took = 1'b0;
      if (tbl_flag[r] & F_ACC) begin
        oc = opcode_of(s);
        if (s == SYM_ID || s == SYM_CONST) begin
          emit_word(KIND_OPERAND, lr, '0, '0, 1'b0);
        end else if (oc >= 0) begin
          if (op_cnt >= OPERATOR_DEPTH_DEF) begin
            stack_overflow();
            return;
          end
          op_stk[op_cnt] = OPC_W'(oc);
          op_cnt++;
        end
        took = 1'b1;
      end
      case (tbl_act[r])
        ACT_ASG: emit_word(KIND_ASSIGN, '0, '0, '0, 1'b0);
        ACT_AEM: emit_word(KIND_ELEMENT, '0, '0, '0, 1'b0);
        ACT_POP: begin
          // pop on an empty operator stack emits nothing
          if (op_cnt > 0) begin
            op_cnt--;
            emit_word(KIND_OPERATOR, '0, op_stk[op_cnt], '0, 1'b0);
          end
        end
        default: ;
      endcase
      if (tbl_flag[r] & F_PSH) begin
        if (ret_cnt >= RETURN_DEPTH_DEF) begin
          stack_overflow();
          return;
        end
        ret_stk[ret_cnt] = ROW_W'(r + 1);
        ret_cnt++;
      end
      if (tbl_jump[r] != '0) begin
        cur_row = tbl_jump[r];
      end else if (tbl_flag[r] & F_RET) begin
        if (ret_cnt == 0) begin
          finish_parse();
          return;
        end
        ret_cnt--;
        cur_row = ret_stk[ret_cnt];
      end else begin
        cur_row = ROW_W'(r + 1);
      end
      if (took) return;
    end
  endfunction

  // Work out the words one accepted token causes and queue them.
  function automatic void predict_words(logic [SYM_W-1:0] s, logic [REF_W-1:0] lr);
    words_now.delete();
    if (is_halted) return;
    cur_pos = tok_index;
    if (tok_index != '1) tok_index++;
    if (in_panic) begin
      if (s == SYM_SEMI) begin
        in_panic = 1'b0;
        back_to_statements();
      end else if (s == SYM_INT || s == SYM_FLOAT) begin
        in_panic = 1'b0;
        back_to_statements();
        walk_rows(s, lr);
      end else if (s == SYM_EOF) begin
        finish_parse();
      end
    end else begin
      walk_rows(s, lr);
    end
    if (words_now.size() > 0) words_now[words_now.size()-1].last = 1'b1;
    foreach (words_now[i]) rpn_owed.insert(rpn_owed.size(), words_now[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Token source
  // ---------------------------------------------------------------------
  token_t tok_buf [$];

  task automatic send_token(logic [SYM_W-1:0] s, logic [REF_W-1:0] lr);
    while ($urandom_range(99) < src_idle_pct) begin
      tok.valid <= 1'b0;
      @(posedge clk);
    end
    tok.valid      <= 1'b1;
    tok.token_sym  <= s;
    tok.lexeme_ref <= lr;
    do @(posedge clk); while (!tok.ready);
    predict_words(s, lr);
    sent_cnt++;
  endtask

  task automatic flush_tokens();
    while (tok_buf.size() > 0) begin
      send_token(tok_buf[0].sym, tok_buf[0].lref);
      void'(tok_buf.pop_front());
    end
  endtask

  task automatic idle_source();
    tok.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_source();
    while (rpn_owed.size() > 0) @(posedge clk);
  endtask

  // Hold the receiver off for a number of cycles.
  task automatic hold_sink(int cycles);
    sink_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    sink_hold = 1'b0;
  endtask

  function automatic void add_tok(logic [SYM_W-1:0] s);
    token_t t;
    t.sym  = s;
    t.lref = REF_W'($urandom);
    tok_buf.insert(tok_buf.size(), t);
  endfunction

  function automatic void add_ref(logic [SYM_W-1:0] s, logic [REF_W-1:0] lr);
    token_t t;
    t.sym  = s;
    t.lref = lr;
    tok_buf.insert(tok_buf.size(), t);
  endfunction

  // Well-formed expression generators; d bounds the bracket nesting.
  task automatic gen_factor(int d);
    int n;
    case ($urandom_range(d > 0 ? 2 : 1))
      0: begin
        add_tok(SYM_ID);
        if (d > 0 && $urandom_range(3) == 0) begin
          add_tok(T_LBR);
          gen_expr(d - 1);
          add_tok(T_RBR);
        end
      end
      1: add_tok(SYM_CONST);
      default: begin
        add_tok(T_LBR);
        gen_expr(d - 1);
        n = $urandom_range(2);
        repeat (n) begin
          add_tok(T_COMMA);
          gen_expr(d - 1);
        end
        add_tok(T_RBR);
      end
    endcase
  endtask

  task automatic gen_term(int d);
    int n;
    gen_factor(d);
    n = $urandom_range(2);
    repeat (n) begin
      add_tok(SYM_MUL);
      gen_factor(d);
    end
  endtask

  task automatic gen_sum(int d);
    int n;
    gen_term(d);
    n = $urandom_range(2);
    repeat (n) begin
      add_tok($urandom_range(1) ? SYM_PLUS : SYM_MINUS);
      gen_term(d);
    end
  endtask

  task automatic gen_expr(int d);
    logic [SYM_W-1:0] rel [4];
    rel = '{SYM_EQ, SYM_NE, SYM_LT, SYM_GT};
    gen_sum(d);
    if ($urandom_range(2) == 0) begin
      add_tok(rel[$urandom_range(3)]);
      gen_sum(d);
    end
  endtask

  task automatic gen_statement();
    logic [SYM_W-1:0] ty;
    ty = $urandom_range(1) ? SYM_FLOAT : SYM_INT;
    case ($urandom_range(4))
      0: begin
        add_tok(ty); add_tok(SYM_ID);
      end
      1: begin
        add_tok(ty); add_tok(SYM_ID); add_tok(T_BECOMES); gen_expr($urandom_range(2));
      end
      2: begin
        add_tok(ty); add_tok(SYM_ID); add_tok(T_LBR); add_tok(SYM_CONST); add_tok(T_RBR);
      end
      3: begin
        add_tok(SYM_ID); add_tok(T_BECOMES); gen_expr($urandom_range(2));
      end
      default: begin
        add_tok(SYM_ID); add_tok(T_LBR); gen_expr($urandom_range(1)); add_tok(T_RBR);
        add_tok(T_BECOMES); gen_expr($urandom_range(1));
      end
    endcase
    add_tok(SYM_SEMI);
  endtask

  // Random symbol that never ends the parse: any code but eof.
  function automatic logic [SYM_W-1:0] noise_sym();
    logic [SYM_W-1:0] s;
    do s = SYM_W'($urandom_range(31)); while (s == SYM_EOF);
    return s;
  endfunction

  // Mostly clean statements; the rest are cut-off or corrupted statements
  // and noise bursts. Hold back on faults while leaked operators pile up.
  task automatic run_random(int count);
    int stop_at;
    int cut;
    int pick;
    stop_at = sent_cnt + count;
    while (sent_cnt < stop_at) begin
      pick = $urandom_range(99);
      if (op_cnt > 20 || pick < 75) begin
        gen_statement();
      end else if (pick < 88) begin
        gen_statement();
        cut = $urandom_range(tok_buf.size() - 1);
        if ($urandom_range(1)) begin
          tok_buf[cut].sym = noise_sym();
        end else begin
          while (tok_buf.size() > cut + 1) void'(tok_buf.pop_back());
        end
      end else begin
        repeat ($urandom_range(1, 3)) add_tok(noise_sym());
      end
      flush_tokens();
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    // int x = 0 + c * 4095 ;  (operand extremes, + and *)
    add_tok(SYM_INT); add_ref(SYM_ID, 12'd0); add_tok(T_BECOMES);
    add_ref(SYM_CONST, 12'd0); add_tok(SYM_PLUS); add_ref(SYM_ID, 12'hFFF);
    add_tok(SYM_MUL); add_ref(SYM_CONST, 12'hFFF); add_tok(SYM_SEMI);
    // y [ a ] = [ b , c - d ] == e ;  (element markers, list, - and ==)
    add_tok(SYM_ID); add_tok(T_LBR); add_tok(SYM_ID); add_tok(T_RBR); add_tok(T_BECOMES);
    add_tok(T_LBR); add_tok(SYM_ID); add_tok(T_COMMA); add_tok(SYM_ID); add_tok(SYM_MINUS);
    add_tok(SYM_ID); add_tok(T_RBR); add_tok(SYM_EQ); add_tok(SYM_CONST); add_tok(SYM_SEMI);
    flush_tokens();
    // float z [ 3 ] ;  then z = a != b ; z = a < b ; z = a > b ;
    add_tok(SYM_FLOAT); add_tok(SYM_ID); add_tok(T_LBR); add_tok(SYM_CONST);
    add_tok(T_RBR); add_tok(SYM_SEMI);
    add_tok(SYM_ID); add_tok(T_BECOMES); add_tok(SYM_ID); add_tok(SYM_NE); add_tok(SYM_ID);
    add_tok(SYM_SEMI);
    add_tok(SYM_ID); add_tok(T_BECOMES); add_tok(SYM_ID); add_tok(SYM_LT); add_tok(SYM_ID);
    add_tok(SYM_SEMI);
    add_tok(SYM_ID); add_tok(T_BECOMES); add_tok(SYM_ID); add_tok(SYM_GT); add_tok(SYM_ID);
    add_tok(SYM_SEMI);
    flush_tokens();
    // errors: recover on ';', on a type keyword at the error, and while skipping
    add_tok(T_RBR); add_tok(SYM_SEMI);
    add_tok(SYM_ID); add_tok(SYM_INT); add_tok(SYM_ID); add_tok(SYM_SEMI);
    add_tok(SYM_KNOWN); add_tok(T_JUNK); add_tok(SYM_PLUS); add_tok(SYM_FLOAT);
    add_tok(SYM_ID); add_tok(SYM_SEMI);
    // leave an operator behind, then recover
    add_tok(SYM_ID); add_tok(T_BECOMES); add_tok(SYM_ID); add_tok(SYM_PLUS);
    add_tok(SYM_SEMI);
    flush_tokens();
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(70);
    wait_drained();
  endtask

  task automatic test_random_source_idle();
    src_idle_pct = 54;
    snk_idle_pct = 0;
    run_random(70);
    wait_drained();
  endtask

  task automatic test_random_sink_stall();
    src_idle_pct = 0;
    snk_idle_pct = 54;
    run_random(70);
    wait_drained();
  endtask

  task automatic test_random_both_idle();
    src_idle_pct = 37;
    snk_idle_pct = 37;
    run_random(70);
    wait_drained();
  endtask

  // Receiver holds off long enough for the block to back up onto the tokens.
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    fork
      hold_sink(400);
    join_none
    run_random(40);
    wait_drained();
  endtask

  // Nest brackets until the return stack overflows; later tokens are dropped.
  task automatic test_overflow_halt();
    src_idle_pct = 0;
    snk_idle_pct = 20;
    add_tok(SYM_ID); add_tok(T_BECOMES);
    repeat (10) add_tok(T_LBR);
    add_tok(SYM_ID); add_tok(SYM_SEMI); add_tok(SYM_EOF); add_tok(SYM_INT);
    flush_tokens();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------
  task automatic report(string what, int got, int want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    rpn_word_t w;
    if (rst) begin
      rpn.ready <= 1'b0;
    end else begin
      if (rpn.valid && rpn.ready) begin
        if (rpn_owed.size() == 0) begin
          report("unexpected word, kind", rpn.out_kind, -1);
        end else begin
          w = rpn_owed.pop_front();
          if (rpn.out_kind !== w.kind) report("out_kind", rpn.out_kind, w.kind);
          if (rpn.operand_ref !== w.oref) report("operand_ref", rpn.operand_ref, w.oref);
          if (rpn.operator_code !== w.opc) report("operator_code", rpn.operator_code, w.opc);
          if (rpn.error_position !== w.pos) report("error_position", rpn.error_position, w.pos);
          if (rpn.finished_with_errors !== w.fe)
            report("finished_with_errors", rpn.finished_with_errors, w.fe);
          if (rpn.last_of_run !== w.last) report("last_of_run", rpn.last_of_run, w.last);
        end
      end
      if (sink_hold) begin
        rpn.ready <= 1'b0;
      end else begin
        rpn.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    tok.valid      <= 1'b0;
    tok.token_sym  <= '0;
    tok.lexeme_ref <= '0;
    rst            <= 1'b1;
    sent_cnt     = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    load_table();
    cur_row   = RESET_ROW;
    ret_cnt   = 0;
    op_cnt    = 0;
    had_error = 1'b0;
    in_panic  = 1'b0;
    is_halted = 1'b0;
    tok_index = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_no_idle();
    test_random_source_idle();
    test_random_sink_stall();
    test_random_both_idle();
    test_backpressure();
    test_overflow_halt();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0 && rpn_owed.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/ll1p_pkg.sv
src/ll1p_tok_if.sv
src/ll1p_rpn_if.sv
src/ll1p_ram.sv
src/ll1p_front.sv
src/ll1p_queue.sv
src/ll1p_back.sv
src/ll1_table_parser_to_rpn.sv
bench/tb_ll1_table_parser_to_rpn.sv
